/* rtl/vda_pkg.sv */
// Shared types, constants and binary32 arithmetic for the vector distance accumulator.
package vda_pkg;

  localparam int unsigned QDEPTH = 4;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
  localparam logic [31:0] POS_ZERO  = 32'h0000_0000;

  localparam logic REG_METRIC = 1'b0;

  typedef enum logic {
    METRIC_L2 = 1'b0,
    METRIC_IP = 1'b1
  } metric_e;

  typedef struct packed {
    logic [31:0] term;
    logic        last;
    metric_e     metric;
  } vda_item_t;

  function automatic logic is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
  endfunction

  // binary32 add, round to nearest even, subnormals kept
  function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [26:0] mb;
    logic [26:0] ms;
    logic [26:0] ms_sh;
    logic        sticky;
    logic [27:0] sum;
    logic [9:0]  e;
    logic [4:0]  lz;
    logic [4:0]  sh;
    logic [26:0] norm;
    logic [7:0]  expf;
    logic        rnd;
    logic [30:0] packed_v;
    logic [31:0] res;
    begin
      if (x[30:0] >= y[30:0]) begin
        big = x;
        sml = y;
      end else begin
        big = y;
        sml = x;
      end
      eb = big[30:23];
      es = sml[30:23];
      mb = {eb != 8'd0, big[22:0], 3'b000};
      ms = {es != 8'd0, sml[22:0], 3'b000};
      d  = ((eb == 8'd0) ? 8'd1 : eb) - ((es == 8'd0) ? 8'd1 : es);
      if (d > 8'd26) begin
        ms_sh  = 27'd0;
        sticky = |ms;
      end else begin
        ms_sh  = ms >> d;
        sticky = |(ms & ((27'd1 << d) - 27'd1));
      end
      ms_sh[0] = ms_sh[0] | sticky;
      if (big[31] == sml[31]) begin
        sum = {1'b0, mb} + {1'b0, ms_sh};
      end else begin
        sum = {1'b0, mb} - {1'b0, ms_sh};
      end
      e  = (eb == 8'd0) ? 10'd1 : {2'b00, eb};
      lz = 5'd27;
      sh = 5'd0;
      if (sum[27]) begin
        norm    = sum[27:1];
        norm[0] = sum[1] | sum[0];
        e       = e + 10'd1;
      end else begin
        for (int i = 0; i < 27; i++) begin
          if (sum[i]) lz = 5'(26 - i);
        end
        if ({5'd0, lz} < (e - 10'd1)) begin
          sh = lz;
        end else begin
          sh = 5'(e - 10'd1);
        end
        norm = sum[26:0] << sh;
        e    = e - {5'd0, sh};
      end
      expf     = norm[26] ? e[7:0] : 8'd0;
      rnd      = norm[2] & (norm[1] | norm[0] | norm[3]);
      packed_v = {expf, norm[25:3]} + {30'd0, rnd};
      res      = {big[31], packed_v};
      if (e >= 10'd255) res = {big[31], 8'hFF, 23'd0};
      if (sum == 28'd0) res = {x[31] & y[31], 31'd0};
      if (is_inf(x) && is_inf(y) && (x[31] != y[31])) begin
        res = CANON_NAN;
      end else if (is_inf(x)) begin
        res = x;
      end else if (is_inf(y)) begin
        res = y;
      end
      if (is_nan(x) || is_nan(y)) res = CANON_NAN;
      return res;
    end
  endfunction

  // binary32 multiply, round to nearest even, subnormals kept
  function automatic logic [31:0] fp_mul(input logic [31:0] x, input logic [31:0] y);
    logic [7:0]         ex;
    logic [7:0]         ey;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic [47:0]        p;
    logic [5:0]         lz;
    logic [47:0]        pn;
    logic signed [10:0] ee;
    logic [10:0]        shr;
    logic               stk;
    logic [7:0]         expf;
    logic               rnd;
    logic [30:0]        packed_v;
    logic               sgn;
    logic [31:0]        res;
    begin
      sgn = x[31] ^ y[31];
      ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      ma  = {x[30:23] != 8'd0, x[22:0]};
      mb  = {y[30:23] != 8'd0, y[22:0]};
      p   = ma * mb;
      lz  = 6'd0;
      for (int i = 0; i < 48; i++) begin
        if (p[i]) lz = 6'(47 - i);
      end
      pn   = p << lz;
      ee   = $signed({3'b000, ex}) + $signed({3'b000, ey}) - 11'sd126
             - $signed({5'b00000, lz});
      expf = ee[7:0];
      if (ee <= 11'sd0) begin
        shr  = 11'(11'sd1 - ee);
        expf = 8'd0;
        if (shr >= 11'd48) begin
          stk = |pn;
          pn  = 48'd0;
        end else begin
          stk = |(pn & ((48'd1 << shr) - 48'd1));
          pn  = pn >> shr;
        end
        pn[0] = pn[0] | stk;
      end
      rnd      = pn[23] & ((|pn[22:0]) | pn[24]);
      packed_v = {expf, pn[46:24]} + {30'd0, rnd};
      res      = {sgn, packed_v};
      if (ee >= 11'sd255) res = {sgn, 8'hFF, 23'd0};
      if ((x[30:0] == 31'd0) || (y[30:0] == 31'd0)) res = {sgn, 31'd0};
      if (is_inf(x) || is_inf(y)) begin
        if ((x[30:0] == 31'd0) || (y[30:0] == 31'd0)) begin
          res = CANON_NAN;
        end else begin
          res = {sgn, 8'hFF, 23'd0};
        end
      end
      if (is_nan(x) || is_nan(y)) res = CANON_NAN;
      return res;
    end
  endfunction

endpackage

/* rtl/vda_front.sv */
// Front end: accepts element pairs and forms a term: the squared difference for L2, the product for inner product.
module vda_front import vda_pkg::*; #(
  parameter int unsigned QDEPTH_P = QDEPTH,
  localparam int unsigned CW = $clog2(QDEPTH_P + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              elem_valid_i,
  output logic              elem_stall_o,
  input  logic [31:0]       element_a_i,
  input  logic [31:0]       element_b_i,
  input  logic              last_element_i,
  input  metric_e           metric_i,
  input  logic [CW-1:0]     q_count_i,
  output logic              push_o,
  output vda_item_t         item_o
);

  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_a_q, s1_b_q;
  logic        s1_last_q;
  metric_e     s1_metric_q;
  logic        s2_valid_q;
  logic [31:0] s2_x_q, s2_y_q, s2_x_d, s2_y_d, diff;
  logic        s2_last_q;
  metric_e     s2_metric_q;
  logic [CW:0] occ;
  logic        accept;

  // queue entries plus words still in flight must fit
  assign occ          = {1'b0, q_count_i} + (CW + 1)'(s1_valid_q) + (CW + 1)'(s2_valid_q);
  assign elem_stall_o = (occ >= (CW + 1)'(QDEPTH_P));
  assign accept       = elem_valid_i & ~elem_stall_o;
  assign s1_valid_d   = accept;

  assign diff   = fp_add(s1_a_q, s1_b_q ^ SIGN_MASK);
  assign s2_x_d = (s1_metric_q == METRIC_IP) ? s1_a_q : diff;
  assign s2_y_d = (s1_metric_q == METRIC_IP) ? s1_b_q : diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_a_q      <= element_a_i;
      s1_b_q      <= element_b_i;
      s1_last_q   <= last_element_i;
      s1_metric_q <= metric_i;
    end
    if (s1_valid_q) begin
      s2_x_q      <= s2_x_d;
      s2_y_q      <= s2_y_d;
      s2_last_q   <= s1_last_q;
      s2_metric_q <= s1_metric_q;
    end
  end

  assign push_o        = s2_valid_q;
  assign item_o.term   = fp_mul(s2_x_q, s2_y_q);
  assign item_o.last   = s2_last_q;
  assign item_o.metric = s2_metric_q;

endmodule

/* rtl/vda_fifo.sv */
// Short queue of terms between front and back end.
module vda_fifo import vda_pkg::*; #(
  parameter int unsigned DEPTH = QDEPTH,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vda_item_t     item_i,
  input  logic          pop_i,
  output vda_item_t     item_o,
  output logic [CW-1:0] count_o
);

  vda_item_t     mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + CW'(1);
    if (!push_i && pop_i) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      if (pop_i)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign item_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

/* rtl/vda_back.sv */
// Back end: accumulates terms and delivers the distance word.
module vda_back import vda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  vda_item_t   item_i,
  output logic        pop_o,
  output logic        dist_valid_o,
  input  logic        dist_stall_i,
  output logic [31:0] distance_value_o
);

  logic [31:0] sum_q, sum_d, nxt, res;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_q;
  logic        slot_free;

  assign slot_free = ~out_valid_q | ~dist_stall_i;
  assign pop_o     = valid_i & (~item_i.last | slot_free);
  assign nxt       = fp_add(sum_q, item_i.term);

  always_comb begin
    res = nxt ^ ((item_i.metric == METRIC_IP) ? SIGN_MASK : 32'd0);
    if (is_nan(res)) res = CANON_NAN;
    sum_d = sum_q;
    if (pop_o) sum_d = item_i.last ? POS_ZERO : nxt;
    out_valid_d = out_valid_q & dist_stall_i;
    if (pop_o && item_i.last) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= POS_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.last) out_q <= res;
  end

  assign dist_valid_o     = out_valid_q;
  assign distance_value_o = out_q;

endmodule

/* rtl/vector_distance_accumulator_top.sv */
// Top level of the float32 vector distance accumulator.
//
// channel   direction  handshake                 payload
// elem      in         elem_valid_i/elem_stall_o element_a_i, element_b_i, last_element_i
// dist      out        dist_valid_o/dist_stall_i distance_value_o
// config    in         APB psel/penable/pready   metric at byte address 0
//
// One element pair per cycle unless the output stalls; the back-end float add is the loop.
// The final term passes the front-end registers and the queue into the output register.
// Reset clears the sum to +0 and metric to squared L2.
// A stalled output holds; the queue then fills and elem_stall_o rises.
module vector_distance_accumulator_top import vda_pkg::*; #(
  parameter int unsigned QDEPTH_P = QDEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        elem_valid_i,
  output logic        elem_stall_o,
  input  logic [31:0] element_a_i,
  input  logic [31:0] element_b_i,
  input  logic        last_element_i,
  output logic        dist_valid_o,
  input  logic        dist_stall_i,
  output logic [31:0] distance_value_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = $clog2(QDEPTH_P + 1);

  metric_e       metric_q, metric_d;
  logic          q_push, q_pop;
  vda_item_t     q_in, q_out;
  logic [CW-1:0] q_count;

  assign pready = 1'b1;

  always_comb begin
    metric_d = metric_q;
    if (psel && penable && pwrite && (paddr[2] == REG_METRIC)) begin
      metric_d = metric_e'(pwdata[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= METRIC_L2;
    end else begin
      metric_q <= metric_d;
    end
  end

  assign prdata = (paddr[2] == REG_METRIC) ? {31'd0, metric_q} : 32'd0;

  vda_front #(.QDEPTH_P(QDEPTH_P)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .elem_valid_i   (elem_valid_i),
    .elem_stall_o   (elem_stall_o),
    .element_a_i    (element_a_i),
    .element_b_i    (element_b_i),
    .last_element_i (last_element_i),
    .metric_i       (metric_q),
    .q_count_i      (q_count),
    .push_o         (q_push),
    .item_o         (q_in)
  );

  vda_fifo #(.DEPTH(QDEPTH_P)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .count_o (q_count)
  );

  vda_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (q_count != '0),
    .item_i           (q_out),
    .pop_o            (q_pop),
    .dist_valid_o     (dist_valid_o),
    .dist_stall_i     (dist_stall_i),
    .distance_value_o (distance_value_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_count != CW'(QDEPTH_P)))
    else $error("queue written while full");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_count != '0))
    else $error("queue read while empty");

  a_last_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_out.last) |=> dist_valid_o)
    else $error("final word not presented");

endmodule

/* test/vector_distance_accumulator_top_test.sv */
// Self-checking testbench for the float32 vector distance accumulator top level.
module vector_distance_accumulator_top_test import vda_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic        last;
  } pair_t;

  localparam logic [31:0] SPECIALS [12] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F80_0000, 32'h0080_0000};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        elem_valid_i = 1'b0;
  logic        elem_stall_o;
  logic [31:0] element_a_i = '0;
  logic [31:0] element_b_i = '0;
  logic        last_element_i = 1'b0;
  logic        dist_valid_o;
  logic        dist_stall_i = 1'b0;
  logic [31:0] distance_value_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pair_t       pair_q[$];
  pair_t       on_bus;
  logic [31:0] distance_expect[$];
  metric_e     metric_mode = METRIC_L2;
  logic [31:0] sum_bits = POS_ZERO;
  logic        calm = 1'b0;
  int          mismatches = 0;

  vector_distance_accumulator_top DUT (.*);

  always #10 clk_i = ~clk_i;

  // binary32 bits to real, exact
  function automatic real to_real(input logic [31:0] f);
    real mag;
    if (f[30:23] == 8'hFF)
      return $bitstoreal({f[31], 11'h7FF, (f[22:0] != 0) ? 52'h8_0000_0000_0000 : 52'd0});
    if (f[30:23] == 8'd0) begin
      mag = real'(f[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
      return f[31] ? -mag : mag;
    end
    return $bitstoreal({f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'd0});
  endfunction

  // real to binary32, round to nearest even with subnormals
  function automatic logic [31:0] to_single(input real r);
    logic [63:0] d;
    logic [63:0] m;
    logic [63:0] kept;
    logic [63:0] v;
    logic        g;
    logic        st;
    int          e;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    m  = {11'd0, 1'b1, d[51:0]};
    e  = int'(d[62:52]) - 1023 + 127;
    sh = (e >= 1) ? 29 : 30 - e;
    if (sh > 60) return {d[63], 31'd0};
    kept = m >> sh;
    g    = m[sh-1];
    st   = |(m & ((64'd1 << (sh - 1)) - 64'd1));
    v    = kept + {63'd0, g & (st | kept[0])} + ((e >= 1) ? (64'(e - 1) << 23) : 64'd0);
    if (v >= 64'h7F80_0000) return {d[63], 8'hFF, 23'd0};
    return {d[63], v[30:0]};
  endfunction

  task automatic accumulate_pair(input pair_t p);
    logic [31:0] term;
    logic [31:0] dist_bits;
    if (metric_mode == METRIC_L2) begin
      term = to_single(to_real(p.a) - to_real(p.b));
      term = to_single(to_real(term) * to_real(term));
    end else begin
      term = to_single(to_real(p.a) * to_real(p.b));
    end
    sum_bits = to_single(to_real(sum_bits) + to_real(term));
    if (p.last) begin
      dist_bits = (metric_mode == METRIC_IP) ? sum_bits ^ SIGN_MASK : sum_bits;
      if (dist_bits[30:23] == 8'hFF && dist_bits[22:0] != 0) dist_bits = CANON_NAN;
      distance_expect.push_back(dist_bits);
      sum_bits = POS_ZERO;
    end
  endtask

  // element driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (elem_valid_i && !elem_stall_o) accumulate_pair(on_bus);
      if (!elem_valid_i || !elem_stall_o) begin
        if (pair_q.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
          on_bus = pair_q.pop_front();
          elem_valid_i   <= 1'b1;
          element_a_i    <= on_bus.a;
          element_b_i    <= on_bus.b;
          last_element_i <= on_bus.last;
        end else begin
          elem_valid_i <= 1'b0;
        end
      end
    end
  end

  // distance monitor
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (dist_valid_o && !dist_stall_i) begin
        if (distance_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected distance word %h", distance_value_o);
        end else begin
          want = distance_expect.pop_front();
          if (distance_value_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("distance mismatch: expected %h got %h", want, distance_value_o);
          end
        end
      end
      dist_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 35);
    end
  end

  task automatic put(input logic [31:0] a, input logic [31:0] b, input logic last);
    pair_q.push_back('{a: a, b: b, last: last});
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(9))
      0: return SPECIALS[$urandom_range(11)];
      1, 2: return $urandom;
      default: return {1'($urandom), 8'($urandom_range(140, 110)), 23'($urandom)};
    endcase
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pair_q.size() != 0 || elem_valid_i || distance_expect.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_metric(input metric_e m);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 3'({REG_METRIC, 2'b00});
    pwdata  <= {31'd0, m};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    metric_mode = m;
  endtask

  task automatic random_vectors(input int count);
    int len;
    int n;
    n = 0;
    while (n < count) begin
      calm = (n > count / 3 && n < count / 2);
      if ($urandom_range(9) == 0) begin
        put($urandom, $urandom, 1'($urandom));
        n++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
        for (int i = 0; i < len; i++) put(rand_elem(), rand_elem(), i == len - 1);
        n += len;
      end
      while (pair_q.size() >= 8) @(posedge clk_i);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // squared L2: extremes, cancellation, inf - inf, overflow, subnormals
    put(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    put(32'h3F80_0000, 32'h3F80_0000, 1'b1);
    put(32'h7F80_0000, 32'h7F80_0000, 1'b1);
    put(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b1);
    put(32'h0000_0001, 32'h8000_0001, 1'b0);
    put(32'h0080_0000, 32'h0000_0000, 1'b1);
    put(32'h4000_0000, 32'h3F80_0000, 1'b0);
    put(32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
    put(32'hC040_0000, 32'h4040_0000, 1'b0);
    wait_idle();
    write_metric(METRIC_IP);
    // inner product: zero sum negated, inf times zero, opposing infinities
    put(32'h3F80_0000, 32'h3F80_0000, 1'b1);
    put(32'h0000_0000, 32'h3F80_0000, 1'b1);
    put(32'h7F80_0000, 32'h0000_0000, 1'b1);
    put(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0);
    put(32'hFF7F_FFFF, 32'h7F7F_FFFF, 1'b1);
    put(32'h0000_0001, 32'h3F00_0000, 1'b1);
    put(32'h3F80_0000, 32'hBF80_0000, 1'b0);
    put(32'h3F80_0000, 32'h3F80_0000, 1'b1);
    put(32'h4049_0FDB, 32'hC02D_F854, 1'b0);
    // metric changes mid-vector
    wait_idle();
    write_metric(METRIC_L2);
    put(32'h4040_0000, 32'h3F80_0000, 1'b1);
    put(32'h4000_0000, 32'h3F80_0000, 1'b0);
    wait_idle();
    write_metric(METRIC_IP);
    put(32'h4000_0000, 32'h4040_0000, 1'b1);
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_metric(metric_e'(ph[0]));
      random_vectors(270);
    end
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
